// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker.
// No dependencies; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/pei_pkg.sv -----
// Shared types, widths and constants of the polynomial evaluator.
// No dependencies; used by pei_cell, the top level and the checker.
package pei_pkg;

    localparam int NUM_REGS        = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int COEF_W          = 32;
    localparam int ACC_W           = 64;
    localparam int DEF_NUM_COEFFS  = 8;
    localparam int DEF_FRAC_BITS   = 24;

    localparam logic signed [ACC_W-1:0] ACC_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 64'shC000_0000_0000_0001;
    localparam logic signed [ACC_W-1:0] OUT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] OUT_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef struct packed {
        logic                     func;
        logic signed [COEF_W-1:0] x_a;
        logic signed [COEF_W-1:0] x_b;
        logic signed [ACC_W-1:0]  acc_a;
        logic signed [ACC_W-1:0]  acc_b;
        logic                     sat_a;
        logic                     sat_b;
    } item_t;

    // round(2^32 / (i + 1))
    function automatic logic [COEF_W:0] recip_const(input logic [CFG_IDX_W-1:0] idx);
        logic [COEF_W:0] r;
        case (idx)
            3'd0:    r = 33'd4294967296;
            3'd1:    r = 33'd2147483648;
            3'd2:    r = 33'd1431655765;
            3'd3:    r = 33'd1073741824;
            3'd4:    r = 33'd858993459;
            3'd5:    r = 33'd715827883;
            3'd6:    r = 33'd613566757;
            3'd7:    r = 33'd536870912;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/pei_cell.sv -----
// One Horner step for both evaluation points: multiply, round/shift, accumulate.
// Three register stages with per-stage valid; depends on pei_pkg.
module pei_cell
#(
    parameter int FRAC_BITS = pei_pkg::DEF_FRAC_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             up_valid,
    output logic                             up_ready,
    input  pei_pkg::item_t                   up_item,
    input  logic signed [pei_pkg::COEF_W-1:0] coef_eval,
    input  logic signed [pei_pkg::COEF_W-1:0] coef_int,
    output logic                             dn_valid,
    input  logic                             dn_ready,
    output pei_pkg::item_t                   dn_item
);
    import pei_pkg::*;

    localparam int MAG_W   = ACC_W - 2;
    localparam int HI_W    = MAG_W - COEF_W;
    localparam int SUM_W   = MAG_W + COEF_W + 1;
    localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic [MAG_W-1:0] MAG_LIM = {MAG_W{1'b1}};

    logic en1;
    logic en2;
    logic en3;

    logic signed [ACC_W-1:0]  acc_in   [2];
    logic signed [COEF_W-1:0] x_in     [2];
    logic [ACC_W-1:0]         acc_mag  [2];
    logic [COEF_W-1:0]        x_mag    [2];
    logic [ACC_W-1:0]         lo_next  [2];
    logic [MAG_W-1:0]         hi_next  [2];
    logic                     neg_next [2];

    logic                     s1_valid_reg;
    logic                     s1_func_reg;
    logic signed [COEF_W-1:0] s1_xa_reg;
    logic signed [COEF_W-1:0] s1_xb_reg;
    logic                     s1_sat_reg [2];
    logic                     s1_neg_reg [2];
    logic [ACC_W-1:0]         s1_lo_reg  [2];
    logic [MAG_W-1:0]         s1_hi_reg  [2];

    logic [SUM_W-1:0]         full_sum   [2];
    logic [MAG_W-1:0]         p_next     [2];
    logic                     ovf_next   [2];

    logic                     s2_valid_reg;
    logic                     s2_func_reg;
    logic signed [COEF_W-1:0] s2_xa_reg;
    logic signed [COEF_W-1:0] s2_xb_reg;
    logic                     s2_sat_reg [2];
    logic                     s2_neg_reg [2];
    logic [MAG_W-1:0]         s2_p_reg   [2];

    logic signed [ACC_W:0]    e_ext;
    logic signed [ACC_W:0]    p_ext      [2];
    logic signed [ACC_W:0]    sum        [2];
    logic signed [ACC_W-1:0]  acc_next   [2];
    logic                     sat_next   [2];

    logic                     s3_valid_reg;
    item_t                    s3_item_reg;

    assign en3      = !s3_valid_reg || dn_ready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign up_ready = en1;
    assign dn_valid = s3_valid_reg;
    assign dn_item  = s3_item_reg;

    assign acc_in[0] = up_item.acc_a;
    assign acc_in[1] = up_item.acc_b;
    assign x_in[0]   = up_item.x_a;
    assign x_in[1]   = up_item.x_b;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            acc_mag[l]  = acc_in[l][ACC_W-1] ? (~acc_in[l] + 1'b1) : acc_in[l];
            x_mag[l]    = x_in[l][COEF_W-1] ? (~x_in[l] + 1'b1) : x_in[l];
            lo_next[l]  = {{COEF_W{1'b0}}, acc_mag[l][COEF_W-1:0]}
                        * {{COEF_W{1'b0}}, x_mag[l]};
            hi_next[l]  = {{COEF_W{1'b0}}, acc_mag[l][MAG_W-1:COEF_W]}
                        * {{HI_W{1'b0}}, x_mag[l]};
            neg_next[l] = acc_in[l][ACC_W-1] ^ x_in[l][COEF_W-1];
        end
    end

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            full_sum[l] = {1'b0, s1_hi_reg[l], {COEF_W{1'b0}}}
                        + {{(SUM_W-ACC_W){1'b0}}, s1_lo_reg[l]} + RND;
            ovf_next[l] = |full_sum[l][SUM_W-1:MAG_W+FRAC_BITS];
            p_next[l]   = ovf_next[l] ? MAG_LIM : full_sum[l][MAG_W+FRAC_BITS-1:FRAC_BITS];
        end
    end

    always_comb
    begin
        e_ext = s2_func_reg ? {{(ACC_W+1-COEF_W){coef_int[COEF_W-1]}}, coef_int}
                            : {{(ACC_W+1-COEF_W){coef_eval[COEF_W-1]}}, coef_eval};
        for (int l = 0; l < 2; l++)
        begin
            p_ext[l]    = {{(ACC_W+1-MAG_W){1'b0}}, s2_p_reg[l]};
            sum[l]      = s2_neg_reg[l] ? (e_ext - p_ext[l]) : (e_ext + p_ext[l]);
            sat_next[l] = s2_sat_reg[l];
            acc_next[l] = sum[l][ACC_W-1:0];
            if (sum[l] > ACC_LIM)
            begin
                acc_next[l] = ACC_LIM;
                sat_next[l] = 1'b1;
            end
            else if (sum[l] < ACC_MIN)
            begin
                acc_next[l] = ACC_MIN;
                sat_next[l] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= up_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_func_reg   <= up_item.func;
            s1_xa_reg     <= up_item.x_a;
            s1_xb_reg     <= up_item.x_b;
            s1_sat_reg[0] <= up_item.sat_a;
            s1_sat_reg[1] <= up_item.sat_b;
            for (int l = 0; l < 2; l++)
            begin
                s1_neg_reg[l] <= neg_next[l];
                s1_lo_reg[l]  <= lo_next[l];
                s1_hi_reg[l]  <= hi_next[l];
            end
        end
        if (en2)
        begin
            s2_func_reg <= s1_func_reg;
            s2_xa_reg   <= s1_xa_reg;
            s2_xb_reg   <= s1_xb_reg;
            for (int l = 0; l < 2; l++)
            begin
                s2_sat_reg[l] <= s1_sat_reg[l] | ovf_next[l];
                s2_neg_reg[l] <= s1_neg_reg[l];
                s2_p_reg[l]   <= p_next[l];
            end
        end
        if (en3)
        begin
            s3_item_reg.func  <= s2_func_reg;
            s3_item_reg.x_a   <= s2_xa_reg;
            s3_item_reg.x_b   <= s2_xb_reg;
            s3_item_reg.acc_a <= acc_next[0];
            s3_item_reg.acc_b <= acc_next[1];
            s3_item_reg.sat_a <= sat_next[0];
            s3_item_reg.sat_b <= sat_next[1];
        end
    end

endmodule

// ----- sv/polynomial_eval_integrate.sv -----
// From request to result: three register stages per Horner cell, then the output
// register. Throughput: one request per cycle unless the output is stalled;
// the cell chain advances with per-stage valids.
// Reset: clears all valid bits and the coefficient registers to zero.
// Holds the coefficient registers, the cell chain and the final subtract/saturate.
// Depends on pei_pkg and pei_cell.
module polynomial_eval_integrate
#(
    parameter int NUM_COEFFS = pei_pkg::DEF_NUM_COEFFS,
    parameter int FRAC_BITS  = pei_pkg::DEF_FRAC_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [pei_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic signed [pei_pkg::COEF_W-1:0]   cfg_data,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                func,
    input  logic signed [pei_pkg::COEF_W-1:0]   x_a,
    input  logic signed [pei_pkg::COEF_W-1:0]   x_b,
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic signed [pei_pkg::COEF_W-1:0]   value,
    output logic                                saturated
);
    import pei_pkg::*;

    localparam int PROD_W = 2 * COEF_W + 1;
    localparam logic [PROD_W-1:0] CFG_HALF = PROD_W'(1) << (COEF_W - 1);

    logic [COEF_W-1:0]        cfg_mag;
    logic [PROD_W-1:0]        cfg_prod;
    logic [PROD_W-1:0]        cfg_rnd;
    logic [COEF_W-1:0]        cfg_q;
    logic signed [COEF_W-1:0] anti_next;

    logic signed [COEF_W-1:0] coef_reg [NUM_COEFFS];
    logic signed [COEF_W-1:0] anti_reg [NUM_COEFFS];
    logic signed [COEF_W-1:0] cell_int [NUM_COEFFS];

    logic  chain_valid [NUM_COEFFS+1];
    logic  chain_ready [NUM_COEFFS+1];
    item_t chain_item  [NUM_COEFFS+1];

    item_t                    last;
    logic                     res_en;
    logic signed [ACC_W-1:0]  diff;
    logic signed [COEF_W-1:0] value_next;
    logic                     saturated_next;
    logic                     res_valid_reg;
    logic signed [COEF_W-1:0] value_reg;
    logic                     saturated_reg;

    // antiderivative coefficient formed as the register is written
    always_comb
    begin
        cfg_mag   = cfg_data[COEF_W-1] ? (~cfg_data + 1'b1) : cfg_data;
        cfg_prod  = {{(COEF_W+1){1'b0}}, cfg_mag} * {{COEF_W{1'b0}}, recip_const(cfg_index)};
        cfg_rnd   = cfg_prod + CFG_HALF;
        cfg_q     = cfg_rnd[2*COEF_W-1:COEF_W];
        anti_next = cfg_data[COEF_W-1] ? (~cfg_q + 1'b1) : cfg_q;
    end

    for (genvar gi = 0; gi < NUM_COEFFS; gi++)
    begin : g_coef
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                coef_reg[gi] <= '0;
                anti_reg[gi] <= '0;
            end
            else if (cfg_wr_en && cfg_index == CFG_IDX_W'(gi))
            begin
                coef_reg[gi] <= cfg_data;
                anti_reg[gi] <= anti_next;
            end
        end
    end

    always_comb
    begin
        chain_item[0].func  = func;
        chain_item[0].x_a   = x_a;
        chain_item[0].x_b   = x_b;
        chain_item[0].acc_a = func ? {{(ACC_W-COEF_W){anti_reg[NUM_COEFFS-1][COEF_W-1]}},
                                      anti_reg[NUM_COEFFS-1]} : '0;
        chain_item[0].acc_b = chain_item[0].acc_a;
        chain_item[0].sat_a = 1'b0;
        chain_item[0].sat_b = 1'b0;
    end

    assign chain_valid[0] = req_valid;
    assign req_stall      = !chain_ready[0];

    for (genvar gk = 0; gk < NUM_COEFFS; gk++)
    begin : g_cell
        if (gk == NUM_COEFFS - 1)
        begin : g_low
            assign cell_int[gk] = '0;
        end
        else
        begin : g_mid
            assign cell_int[gk] = anti_reg[NUM_COEFFS-2-gk];
        end

        pei_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .up_valid  (chain_valid[gk]),
            .up_ready  (chain_ready[gk]),
            .up_item   (chain_item[gk]),
            .coef_eval (coef_reg[NUM_COEFFS-1-gk]),
            .coef_int  (cell_int[gk]),
            .dn_valid  (chain_valid[gk+1]),
            .dn_ready  (chain_ready[gk+1]),
            .dn_item   (chain_item[gk+1])
        );
    end

    assign last                    = chain_item[NUM_COEFFS];
    assign res_en                  = !res_valid_reg || !res_stall;
    assign chain_ready[NUM_COEFFS] = res_en;

    always_comb
    begin
        diff           = last.func ? (last.acc_b - last.acc_a) : last.acc_a;
        saturated_next = last.sat_a | (last.func & last.sat_b);
        value_next     = diff[COEF_W-1:0];
        if (diff > OUT_MAX)
        begin
            value_next     = OUT_MAX[COEF_W-1:0];
            saturated_next = 1'b1;
        end
        else if (diff < OUT_MIN)
        begin
            value_next     = OUT_MIN[COEF_W-1:0];
            saturated_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_en)
        begin
            res_valid_reg <= chain_valid[NUM_COEFFS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_en)
        begin
            value_reg     <= value_next;
            saturated_reg <= saturated_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign value     = value_reg;
    assign saturated = saturated_reg;

endmodule

// ----- sv/pei_checker.sv -----
// Port-level checks of the polynomial evaluator, bound to the top level.
// Depends on pei_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pei_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              req_stall,
    input logic                              res_valid,
    input logic                              res_stall,
    input logic signed [pei_pkg::COEF_W-1:0] value,
    input logic                              saturated
);

    // hold a stalled result
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid)
    `ASSERT_NEXT(a_res_data, clk, rst_n, res_valid && res_stall, $stable(value) && $stable(saturated))
    // a free output slot lets every stage advance
    `ASSERT_NOW(a_req_free, clk, rst_n, !res_valid || !res_stall, !req_stall)
    // a stalled request means a full chain behind the output
    `ASSERT_NEXT(a_full_chain, clk, rst_n, req_stall, res_valid)

endmodule

bind polynomial_eval_integrate pei_checker u_pei_checker (.*);
